>>> src/asda_pkg.sv
// asda_pkg: shared types and constants for the analog stick digitizer
// no dependencies
`default_nettype none

package asda_pkg;

    // divider width and number of one-bit steps
    localparam int unsigned DIV_W = 32;

    // configuration register indexes
    localparam logic [3:0] REG_FIRE_SPEED = 4'd0;
    localparam logic [3:0] REG_BY_AXIS    = 4'd1;
    localparam logic [3:0] REG_X_MIN      = 4'd2;
    localparam logic [3:0] REG_X_MAX      = 4'd3;
    localparam logic [3:0] REG_Y_MIN      = 4'd4;
    localparam logic [3:0] REG_Y_MAX      = 4'd5;
    localparam logic [3:0] REG_AUX_MIN    = 4'd6;
    localparam logic [3:0] REG_AUX_MAX    = 4'd7;

    // fire speed limits and reset values
    localparam logic [5:0]  SPEED_MIN   = 6'd1;
    localparam logic [5:0]  SPEED_MAX   = 6'd32;
    localparam logic [5:0]  SPEED_RST   = 6'd16;
    localparam logic [15:0] AUX_MAX_RST = 16'd32;

    // side data that travels alongside a division
    typedef struct packed {
        logic [3:0]       dir;
        logic             fire_main;
        logic             fire_auto;
        logic             by_axis;
        logic [5:0]       speed;
        logic [DIV_W-1:0] clk;
    } t_tag;

endpackage

`default_nettype wire

>>> src/asda_div.sv
// asda_div: fully pipelined restoring divider, one quotient bit per stage
// depends on asda_pkg (DIV_W, t_tag)
`default_nettype none

module asda_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [31:0]        i_num,
    input  wire logic [31:0]        i_den,
    input  wire asda_pkg::t_tag     i_tag,
    output logic                    o_valid,
    output logic [31:0]             o_quo,
    output asda_pkg::t_tag          o_tag
);
    import asda_pkg::*;

    logic             r_v   [0:DIV_W];
    logic [DIV_W-1:0] r_rem [0:DIV_W];
    logic [DIV_W-1:0] r_num [0:DIV_W];
    logic [DIV_W-1:0] r_den [0:DIV_W];
    logic [DIV_W-1:0] r_quo [0:DIV_W];
    t_tag             r_tag [0:DIV_W];

    logic [DIV_W:0]   n_trial [0:DIV_W-1];
    logic [DIV_W:0]   n_diff  [0:DIV_W-1];
    logic [DIV_W-1:0] n_rem   [0:DIV_W-1];
    logic             n_ge    [0:DIV_W-1];

    // trial subtract in every stage
    always_comb begin
        for (int k = 0; k < DIV_W; k++) begin
            n_trial[k] = {r_rem[k], r_num[k][DIV_W-1]};
            n_diff[k]  = n_trial[k] - {1'b0, r_den[k]};
            n_ge[k]    = !n_diff[k][DIV_W];
            n_rem[k]   = n_ge[k] ? n_diff[k][DIV_W-1:0] : n_trial[k][DIV_W-1:0];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_W; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int k = 0; k < DIV_W; k++) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_num[0] <= i_num;
        r_den[0] <= i_den;
        r_quo[0] <= '0;
        r_tag[0] <= i_tag;
        for (int k = 0; k < DIV_W; k++) begin
            r_rem[k+1] <= n_rem[k];
            r_num[k+1] <= {r_num[k][DIV_W-2:0], 1'b0};
            r_den[k+1] <= r_den[k];
            r_quo[k+1] <= {r_quo[k][DIV_W-2:0], n_ge[k]};
            r_tag[k+1] <= r_tag[k];
        end
    end

    assign o_valid = r_v[DIV_W];
    assign o_quo   = r_quo[DIV_W];
    assign o_tag   = r_tag[DIV_W];

endmodule

`default_nettype wire

>>> src/analog_stick_digitizer_autofire.sv
// analog_stick_digitizer_autofire: stick poll to 5-bit joystick word with autofire
// depends on asda_pkg and asda_div
//
// channel   | ports                                        | handshake
// poll in   | x/y/aux pos, buttons, cpu_clock              | start high, busy low
// result    | o_stick_bits                                 | o_valid strobe, one cycle
// config    | i_cfg_we, i_cfg_idx, i_cfg_data              | write when i_cfg_we high
//
// one poll per cycle; each result passes through three front stages, then two 33-stage
// dividers in series (axis rate, then clock / rate) with the divisor select stage between
// them, and then the result register
// busy is always low; the pipeline never stalls and the receiver cannot stall
// synchronous active-low reset clears valid bits and loads register defaults
`default_nettype none

module analog_stick_digitizer_autofire (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] i_x_pos,
    input  wire logic [15:0] i_y_pos,
    input  wire logic [15:0] i_aux_pos,
    input  wire logic        i_button_main,
    input  wire logic        i_button_auto,
    input  wire logic [31:0] i_cpu_clock,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_valid,
    output logic [4:0]       o_stick_bits
);
    import asda_pkg::*;

    // configuration registers
    logic [5:0]  r_fire_speed;
    logic        r_by_axis;
    logic [15:0] r_x_min, r_x_max, r_y_min, r_y_max, r_aux_min, r_aux_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fire_speed <= SPEED_RST;
            r_by_axis    <= 1'b0;
            r_x_min      <= '0;
            r_x_max      <= '1;
            r_y_min      <= '0;
            r_y_max      <= '1;
            r_aux_min    <= '0;
            r_aux_max    <= AUX_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FIRE_SPEED: begin
                    if (i_cfg_data[5:0] < SPEED_MIN) r_fire_speed <= SPEED_MIN;
                    else if (i_cfg_data[5:0] > SPEED_MAX) r_fire_speed <= SPEED_MAX;
                    else r_fire_speed <= i_cfg_data[5:0];
                end
                REG_BY_AXIS:    r_by_axis <= i_cfg_data[0];
                REG_X_MIN:      r_x_min   <= i_cfg_data;
                REG_X_MAX:      r_x_max   <= i_cfg_data;
                REG_Y_MIN:      r_y_min   <= i_cfg_data;
                REG_Y_MAX:      r_y_max   <= i_cfg_data;
                REG_AUX_MIN:    r_aux_min <= i_cfg_data;
                REG_AUX_MAX:    r_aux_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: spans and axis-rate operands
    logic               r1_v;
    logic [15:0]        r1_xp, r1_yp, r1_xmin, r1_ymin;
    logic signed [16:0] r1_dx, r1_dy;
    logic [31:0]        r1_num, r1_span;
    t_tag               r1_tag;
    logic [16:0]        n1_asum;
    logic [31:0]        n1_adiff;

    assign n1_asum  = {1'b0, r_aux_min} + {1'b0, i_aux_pos};
    assign n1_adiff = {16'd0, r_aux_max} - {16'd0, r_aux_min};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= start;
    end

    always_ff @(posedge i_clk) begin
        r1_xp   <= i_x_pos;
        r1_yp   <= i_y_pos;
        r1_xmin <= r_x_min;
        r1_ymin <= r_y_min;
        r1_dx   <= $signed({1'b0, r_x_max}) - $signed({1'b0, r_x_min});
        r1_dy   <= $signed({1'b0, r_y_max}) - $signed({1'b0, r_y_min});
        r1_num  <= {2'b00, n1_asum, 13'd0};
        r1_span <= (r_aux_max == r_aux_min) ? 32'd1 : n1_adiff;
        r1_tag.dir       <= '0;
        r1_tag.fire_main <= i_button_main;
        r1_tag.fire_auto <= i_button_auto;
        r1_tag.by_axis   <= r_by_axis;
        r1_tag.speed     <= r_fire_speed;
        r1_tag.clk       <= i_cpu_clock;
    end

    // stage 2: quarter-point thresholds
    function automatic logic signed [18:0] quarter(input logic signed [16:0] d);
        logic signed [16:0] adj;
        adj = d + (d[16] ? 17'sd3 : 17'sd0);
        return 19'(adj >>> 2);
    endfunction

    logic               r2_v;
    logic [15:0]        r2_xp, r2_yp;
    logic signed [18:0] r2_xlo, r2_xhi, r2_ylo, r2_yhi;
    logic [31:0]        r2_num, r2_span;
    t_tag               r2_tag;
    logic signed [18:0] n2_qx, n2_qy;

    assign n2_qx = quarter(r1_dx);
    assign n2_qy = quarter(r1_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
    end

    always_ff @(posedge i_clk) begin
        r2_xp   <= r1_xp;
        r2_yp   <= r1_yp;
        r2_xlo  <= $signed({3'b000, r1_xmin}) + n2_qx;
        r2_xhi  <= $signed({3'b000, r1_xmin}) + n2_qx + (n2_qx <<< 1);
        r2_ylo  <= $signed({3'b000, r1_ymin}) + n2_qy;
        r2_yhi  <= $signed({3'b000, r1_ymin}) + n2_qy + (n2_qy <<< 1);
        r2_num  <= r1_num;
        r2_span <= r1_span;
        r2_tag  <= r1_tag;
    end

    // stage 3: direction compares
    logic               r3_v;
    logic [31:0]        r3_num, r3_span;
    t_tag               r3_tag;
    logic signed [18:0] n3_x, n3_y;
    t_tag               n3_tag;

    assign n3_x = $signed({3'b000, r2_xp});
    assign n3_y = $signed({3'b000, r2_yp});

    // bit0 up, bit1 down, bit2 left, bit3 right
    always_comb begin
        n3_tag     = r2_tag;
        n3_tag.dir = {n3_x >= r2_xhi, n3_x <= r2_xlo, n3_y >= r2_yhi, n3_y <= r2_ylo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
    end

    always_ff @(posedge i_clk) begin
        r3_num  <= r2_num;
        r3_span <= r2_span;
        r3_tag  <= n3_tag;
    end

    // axis rate division
    logic        d1_v;
    logic [31:0] d1_quo;
    t_tag        d1_tag;

    asda_div u_rate_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_v),
        .i_num   (r3_num),
        .i_den   (r3_span),
        .i_tag   (r3_tag),
        .o_valid (d1_v),
        .o_quo   (d1_quo),
        .o_tag   (d1_tag)
    );

    // stage 4: pick the autofire divisor
    logic        r4_v;
    logic [31:0] r4_den;
    t_tag        r4_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= d1_v;
    end

    always_ff @(posedge i_clk) begin
        r4_den <= d1_tag.by_axis ? (d1_quo + 32'd1) : {18'd0, d1_tag.speed, 8'd0};
        r4_tag <= d1_tag;
    end

    // cpu clock over rate
    logic        d2_v;
    logic [31:0] d2_quo;
    t_tag        d2_tag;

    asda_div u_clk_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_v),
        .i_num   (r4_tag.clk),
        .i_den   (r4_den),
        .i_tag   (r4_tag),
        .o_valid (d2_v),
        .o_quo   (d2_quo),
        .o_tag   (d2_tag)
    );

    // result register
    logic       r_out_v;
    logic [4:0] r_stick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else          r_out_v <= d2_v;
    end

    always_ff @(posedge i_clk) begin
        r_stick <= {d2_tag.fire_main | (d2_tag.fire_auto & d2_quo[4]), d2_tag.dir};
    end

    assign o_valid      = r_out_v;
    assign o_stick_bits = r_stick;

endmodule

`default_nettype wire

>>> tb/analog_stick_digitizer_autofire_tb.sv
// analog_stick_digitizer_autofire_tb: self-checking bench for the stick digitizer
// depends on asda_pkg and analog_stick_digitizer_autofire (with its dividers)
`default_nettype none

module analog_stick_digitizer_autofire_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asda_pkg::*;

    localparam int LATENCY   = 70;
    localparam int CYCLE_CAP = 400000;

    typedef struct packed {
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [15:0] aux_pos;
        logic        button_main;
        logic        button_auto;
        logic [31:0] cpu_clock;
    } t_poll;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_x_pos = '0;
    logic [15:0] i_y_pos = '0;
    logic [15:0] i_aux_pos = '0;
    logic        i_button_main = 1'b0;
    logic        i_button_auto = 1'b0;
    logic [31:0] i_cpu_clock = '0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_valid;
    logic [4:0]  o_stick_bits;

    analog_stick_digitizer_autofire u_top (.*);

    always #10 i_clk = ~i_clk;

    // predictor copy of the register file
    logic [5:0]  speed_q;
    logic        by_axis_q;
    logic [15:0] x_min_q, x_max_q, y_min_q, y_max_q, aux_min_q, aux_max_q;

    t_poll      poll_queue[$];
    logic [4:0] word_queue[$];
    int         idle_pct = 0;
    int         error_count = 0;
    int         polls_sent = 0;
    int         words_seen = 0;
    longint     cycle_count = 0;

    // low zone bit0, high zone bit1, signed thresholds
    function automatic logic [1:0] zone_of(logic [15:0] pos, logic [15:0] lo,
                                           logic [15:0] hi);
        longint q;
        longint mn;
        mn = longint'(lo);
        q  = (longint'(hi) - mn) / 4;
        zone_of[0] = longint'(pos) <= mn + q;
        zone_of[1] = longint'(pos) >= mn + 3 * q;
    endfunction

    function automatic logic [4:0] stick_word(t_poll p);
        logic [1:0]  z;
        logic [31:0] span;
        logic [31:0] divisor;
        logic [31:0] quot;
        z = zone_of(p.x_pos, x_min_q, x_max_q);
        stick_word[2] = z[0];
        stick_word[3] = z[1];
        z = zone_of(p.y_pos, y_min_q, y_max_q);
        stick_word[0] = z[0];
        stick_word[1] = z[1];
        stick_word[4] = p.button_main;
        if (p.button_auto) begin
            if (by_axis_q) begin
                span = 32'(aux_max_q) - 32'(aux_min_q);
                if (span == 0) span = 1;
                divisor = ((32'(aux_min_q) + 32'(p.aux_pos)) * 32'h2000) / span + 1;
            end else begin
                divisor = 32'(speed_q) * 32'h100;
            end
            quot = p.cpu_clock / divisor;
            stick_word[4] = stick_word[4] | quot[4];
        end
    endfunction

    task automatic report(string what, logic [4:0] got, logic [4:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // register write through the config port, mirrored into the predictor
    task automatic write_reg(logic [3:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_FIRE_SPEED: begin
                if (val[5:0] < SPEED_MIN) speed_q = SPEED_MIN;
                else if (val[5:0] > SPEED_MAX) speed_q = SPEED_MAX;
                else speed_q = val[5:0];
            end
            REG_BY_AXIS: by_axis_q = val[0];
            REG_X_MIN: x_min_q = val;
            REG_X_MAX: x_max_q = val;
            REG_Y_MIN: y_min_q = val;
            REG_Y_MAX: y_max_q = val;
            REG_AUX_MIN: aux_min_q = val;
            REG_AUX_MAX: aux_max_q = val;
            default: ;
        endcase
    endtask

    // drain in-flight polls before touching registers
    task automatic wait_quiet();
        wait (poll_queue.size() == 0 && !start && word_queue.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic t_poll rand_poll();
        t_poll p;
        p.x_pos       = 16'($urandom);
        p.y_pos       = 16'($urandom);
        p.aux_pos     = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 64))
                                                    : 16'($urandom);
        p.button_main = 1'($urandom);
        p.button_auto = ($urandom_range(0, 3) != 0);
        p.cpu_clock   = $urandom;
        return p;
    endfunction

    // driver: one poll per cycle unless idling or held by busy
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (poll_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                t_poll p;
                p = poll_queue.pop_front();
                i_x_pos       <= p.x_pos;
                i_y_pos       <= p.y_pos;
                i_aux_pos     <= p.aux_pos;
                i_button_main <= p.button_main;
                i_button_auto <= p.button_auto;
                i_cpu_clock   <= p.cpu_clock;
                start         <= 1'b1;
                word_queue.push_back(stick_word(p));
                polls_sent++;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid) begin
            words_seen++;
            if (word_queue.size() == 0) report("unexpected word", o_stick_bits, 5'h0);
            else begin
                logic [4:0] want;
                want = word_queue.pop_front();
                if (o_stick_bits !== want) report("stick_bits", o_stick_bits, want);
            end
        end
    end

    // stimulus
    initial begin
        t_poll p;
        int    phase;
        speed_q = SPEED_RST; by_axis_q = 1'b0;
        x_min_q = 0; x_max_q = 16'hFFFF; y_min_q = 0; y_max_q = 16'hFFFF;
        aux_min_q = 0; aux_max_q = AUX_MAX_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes and thresholds at reset settings
        p = '0;                                          poll_queue.push_back(p);
        p = '1;                                          poll_queue.push_back(p);
        p = '0; p.x_pos = 16'd16383; p.y_pos = 16'd16384; poll_queue.push_back(p);
        p = '0; p.x_pos = 16'd49149; p.y_pos = 16'd49148; poll_queue.push_back(p);
        p = '0; p.button_main = 1; p.cpu_clock = 32'h0000_1000; poll_queue.push_back(p);
        p = '0; p.button_auto = 1; p.cpu_clock = 32'h0001_0000; poll_queue.push_back(p);
        p = '0; p.button_auto = 1; p.cpu_clock = 32'hFFFF_FFFF; poll_queue.push_back(p);
        p = '0; p.button_auto = 1; p.cpu_clock = 32'h0000_FFFF; poll_queue.push_back(p);
        wait_quiet();

        // zero speed clamps up, min above max, zero aux span, axis mode, unused index write
        write_reg(REG_FIRE_SPEED, 16'd0);
        write_reg(REG_X_MIN, 16'hFFFF); write_reg(REG_X_MAX, 16'd0);
        write_reg(REG_Y_MIN, 16'd100);  write_reg(REG_Y_MAX, 16'd100);
        write_reg(REG_AUX_MIN, 16'd500); write_reg(REG_AUX_MAX, 16'd500);
        write_reg(REG_BY_AXIS, 16'd1);
        write_reg(4'd9, 16'hFFFF);
        p = '0; p.button_auto = 1; p.cpu_clock = 32'h00FF_FFFF;  poll_queue.push_back(p);
        p = '1;                                                  poll_queue.push_back(p);
        p = '0; p.x_pos = 16'hFFFF; p.y_pos = 16'd100;           poll_queue.push_back(p);
        p = '1; p.aux_pos = 16'hFFFF; p.button_main = 0;         poll_queue.push_back(p);
        wait_quiet();
        // wrapped aux span and speed above limit, then the last poll again in speed mode
        write_reg(REG_AUX_MIN, 16'hFFFF); write_reg(REG_AUX_MAX, 16'd0);
        write_reg(REG_FIRE_SPEED, 16'h003F);
        p = '1; p.button_main = 0; poll_queue.push_back(p);
        p = '0; p.button_auto = 1; p.cpu_clock = 32'h8000_0000; poll_queue.push_back(p);
        wait_quiet();
        write_reg(REG_BY_AXIS, 16'd0);
        poll_queue.push_back(p);
        wait_quiet();

        // random phases over several settings and idling levels
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: idle_pct = 0;
                1: idle_pct = 58;
                2: idle_pct = 7;
                default: idle_pct = 0;
            endcase
            write_reg(REG_FIRE_SPEED, 16'($urandom_range(0, 63)));
            write_reg(REG_BY_AXIS, 16'($urandom));
            write_reg(REG_X_MIN, 16'($urandom)); write_reg(REG_X_MAX, 16'($urandom));
            write_reg(REG_Y_MIN, 16'($urandom_range(0, 20000)));
            write_reg(REG_Y_MAX, 16'($urandom_range(40000, 65535)));
            write_reg(REG_AUX_MIN, 16'($urandom_range(0, 200)));
            write_reg(REG_AUX_MAX, (phase == 7) ? 16'hFFFF : 16'($urandom));
            repeat (140) poll_queue.push_back(rand_poll());
            wait_quiet();
        end

        $display("summary: %0d polls over directed corners and 8 random register sets",
                 polls_sent);
        $display("summary: %0d result words checked, %0d errors", words_seen,
                 error_count);
        if (error_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout with %0d words outstanding", word_queue.size());
            $display("TEST FAILED");
            $finish;
        end
    end
endmodule

`default_nettype wire

>>> analog_stick_digitizer_autofire.f
src/asda_pkg.sv
src/asda_div.sv
src/analog_stick_digitizer_autofire.sv
tb/analog_stick_digitizer_autofire_tb.sv
